### rtl/core/text_console_writer_defines.svh
// Assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// Package: screen geometry, character codes, types and address helper
package tcw_pkg;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int SCROLL_BASE = CELL_COUNT - SCREEN_COLS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam int                TAB_STEP   = 4;

  localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = {COLOR_RESET, CH_SPACE};

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(32'(row) * SCREEN_COLS + 32'(col));
  endfunction

endpackage

### rtl/core/tcw_in_if.sv
// Input channel: one console item
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, output action, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input action, input char_code, input read_row,
                  input read_col, output ready);
endinterface

### rtl/core/tcw_out_if.sv
// Output channel: one result item
interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_entry;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  modport source (output valid, output cell_entry, output cursor_row,
                  output cursor_col, input ready);
  modport sink   (input valid, input cell_entry, input cursor_row,
                  input cursor_col, output ready);
endinterface

### rtl/core/tcw_cfg_if.sv
// Configuration write channel: text color register
interface tcw_cfg_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_color;

  modport source (output valid, output text_color, input ready);
  modport sink   (input valid, input text_color, output ready);
endinterface

### rtl/core/text_console_writer.sv
// A printable character, CR, tab or newline without scroll gives its result in the cycle after
// acceptance; a cell read passes the screen memory read register, then the result register.
// Scroll and clear walk the screen memory one cell per cycle. Throughput: one put item per
// cycle while no scroll occurs and the output is ready; a read holds off the next item until
// its result is registered. Reset: cursor homes, color 0x07; a clearing pass then blanks the
// store before the first item is taken. Color writes are taken at any time.
module text_console_writer import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o,
  tcw_cfg_if.sink   cfg_i
);

  logic [CHAR_W-1:0] text_color_q;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] rd_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= COLOR_RESET;
    end else if (cfg_i.valid) begin
      text_color_q <= cfg_i.text_color;
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .text_color_i (text_color_q),
    .mem_req_o    (mem_req),
    .rd_data_i    (rd_data)
  );

  tcw_screen_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

### rtl/core/tcw_screen_ram.sv
// Screen store: one write port, one registered read port
module tcw_screen_ram import tcw_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [CELL_W-1:0] rd_data_o
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/tcw_ctrl.sv
// Controller: cursor, item handling, scroll/clear sweeps and result register
module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_in_if.sink            in_i,
  tcw_out_if.source         out_o,
  input  logic [CHAR_W-1:0] text_color_i,
  output mem_req_t          mem_req_o,
  input  logic [CELL_W-1:0] rd_data_i
);

  state_e state_q, state_d;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              sweep_copy_q, sweep_copy_d;
  logic              sweep_item_q, sweep_item_d;
  logic [CELL_W-1:0] sweep_fill_q, sweep_fill_d;
  logic              stg_we_q, stg_we_d;
  logic [ADDR_W-1:0] stg_addr_q, stg_addr_d;
  logic              stg_copy_q, stg_copy_d;
  logic              rd_hit_q, rd_hit_d;
  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] out_cell_q, out_cell_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;

  logic              in_ready, in_fire, rd_hit, sweep_copy_now, cnt_last;
  action_e           act;

  // put-character decode
  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc, col_tab;
  logic [ROW_W-1:0]  nl_row, put_row;
  logic [COL_W-1:0]  put_col;
  logic              nl_scroll, put_scroll, put_we;

  assign act      = action_e'(in_i.action);
  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire  = in_i.valid && in_ready;
  assign rd_hit   = (32'(in_i.read_row) < SCREEN_ROWS) && (32'(in_i.read_col) < SCREEN_COLS);
  assign cnt_last = (cnt_q == ADDR_W'(CELL_COUNT - 1));
  assign sweep_copy_now = sweep_copy_q && (32'(cnt_q) < SCROLL_BASE);

  assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);
  assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);
  assign col_tab = {1'b0, col_q} + (COL_W+1)'(TAB_STEP);

  always_comb begin
    if (32'(row_inc) >= SCREEN_ROWS) begin
      nl_row    = ROW_W'(SCREEN_ROWS - 1);
      nl_scroll = 1'b1;
    end else begin
      nl_row    = row_inc[ROW_W-1:0];
      nl_scroll = 1'b0;
    end
  end

  always_comb begin
    put_row    = row_q;
    put_col    = col_q;
    put_scroll = 1'b0;
    put_we     = 1'b0;
    case (in_i.char_code)
      CH_NEWLINE: begin
        put_row    = nl_row;
        put_col    = '0;
        put_scroll = nl_scroll;
      end
      CH_RETURN: begin
        put_col = '0;
      end
      CH_TAB: begin
        if (32'(col_tab) >= SCREEN_COLS) begin
          put_row    = nl_row;
          put_col    = '0;
          put_scroll = nl_scroll;
        end else begin
          put_col = col_tab[COL_W-1:0];
        end
      end
      default: begin
        put_we = 1'b1;
        if (32'(col_inc) >= SCREEN_COLS) begin
          put_row    = nl_row;
          put_col    = '0;
          put_scroll = nl_scroll;
        end else begin
          put_col = col_inc[COL_W-1:0];
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (act)
            ACT_PUT:   state_d = put_scroll ? ST_SWEEP : ST_IDLE;
            ACT_CLEAR: state_d = ST_SWEEP;
            ACT_READ:  state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_SWEEP: state_d = cnt_last ? ST_FLUSH : ST_SWEEP;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    cnt_d        = cnt_q;
    sweep_copy_d = sweep_copy_q;
    sweep_item_d = sweep_item_q;
    sweep_fill_d = sweep_fill_q;
    stg_we_d     = 1'b0;
    stg_addr_d   = cnt_q;
    stg_copy_d   = 1'b0;
    rd_hit_d     = rd_hit_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_cell_d   = out_cell_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;

    // sweep write stage is registered and writes in the cycle after its read
    mem_req_o.we    = stg_we_q;
    mem_req_o.waddr = stg_addr_q;
    mem_req_o.wdata = stg_copy_q ? rd_data_i : sweep_fill_q;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (act)
            ACT_PUT: begin
              row_d           = put_row;
              col_d           = put_col;
              mem_req_o.we    = put_we;
              mem_req_o.waddr = cell_addr(row_q, col_q);
              mem_req_o.wdata = {text_color_i, in_i.char_code};
              if (put_scroll) begin
                cnt_d        = '0;
                sweep_copy_d = 1'b1;
                sweep_item_d = 1'b1;
                sweep_fill_d = {text_color_i, CH_SPACE};
              end else begin
                out_valid_d = 1'b1;
                out_cell_d  = '0;
                out_row_d   = put_row;
                out_col_d   = put_col;
              end
            end
            ACT_CLEAR: begin
              row_d        = '0;
              col_d        = '0;
              cnt_d        = '0;
              sweep_copy_d = 1'b0;
              sweep_item_d = 1'b1;
              sweep_fill_d = {text_color_i, CH_SPACE};
            end
            ACT_READ: begin
              mem_req_o.re    = rd_hit;
              mem_req_o.raddr = cell_addr(in_i.read_row, in_i.read_col);
              rd_hit_d        = rd_hit;
            end
            default: begin
              out_valid_d = 1'b1;
              out_cell_d  = '0;
              out_row_d   = row_q;
              out_col_d   = col_q;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_cell_d  = rd_hit_q ? rd_data_i : '0;
        out_row_d   = row_q;
        out_col_d   = col_q;
      end
      ST_SWEEP: begin
        stg_we_d        = 1'b1;
        stg_addr_d      = cnt_q;
        stg_copy_d      = sweep_copy_now;
        mem_req_o.re    = sweep_copy_now;
        mem_req_o.raddr = ADDR_W'(32'(cnt_q) + SCREEN_COLS);
        cnt_d           = cnt_q + ADDR_W'(1);
      end
      ST_FLUSH: begin
        if (sweep_item_q) begin
          out_valid_d = 1'b1;
          out_cell_d  = '0;
          out_row_d   = row_q;
          out_col_d   = col_q;
        end
      end
      default: begin
      end
    endcase
  end

  // after reset the store is swept with the power-on blank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      row_q        <= '0;
      col_q        <= '0;
      cnt_q        <= '0;
      sweep_copy_q <= 1'b0;
      sweep_item_q <= 1'b0;
      sweep_fill_q <= BLANK_RESET;
      stg_we_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      cnt_q        <= cnt_d;
      sweep_copy_q <= sweep_copy_d;
      sweep_item_q <= sweep_item_d;
      sweep_fill_q <= sweep_fill_d;
      stg_we_q     <= stg_we_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_addr_q <= stg_addr_d;
    stg_copy_q <= stg_copy_d;
    rd_hit_q   <= rd_hit_d;
    out_cell_q <= out_cell_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.cell_entry = out_cell_q;
  assign out_o.cursor_row = out_row_q;
  assign out_o.cursor_col = out_col_q;

endmodule

### rtl/core/tcw_checker.sv
// Port-level checker for the text console, bound to the top level
`include "text_console_writer_defines.svh"

module tcw_checker import tcw_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);

  `TCW_ASSERT_NEXT(out_hold_a, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.cell_entry) && $stable(out_o.cursor_row) && $stable(out_o.cursor_col), "stalled result item changed")
  `TCW_ASSERT_SAME(row_range_a, out_o.valid, 32'(out_o.cursor_row) < SCREEN_ROWS, "cursor row off screen")
  `TCW_ASSERT_SAME(col_range_a, out_o.valid, 32'(out_o.cursor_col) < SCREEN_COLS, "cursor column off screen")
  `TCW_ASSERT_SAME(stall_a, out_o.valid && !out_o.ready, !in_i.ready, "item taken while result blocked")
  `TCW_ASSERT_NEXT(clear_busy_a, in_i.valid && in_i.ready && in_i.action == ACT_CLEAR, !in_i.ready, "item taken during clear sweep")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

### test/text_console_mirror.sv
// Console mirror: tracks the screen and cursor from the channels and checks every result item
module text_console_mirror import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tcw_in_if    in_mon,
  tcw_out_if   out_mon,
  tcw_cfg_if   cfg_mon,
  output int   mismatch_count_o,
  output int   awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CELL_W-1:0] entry;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_view_t;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [CHAR_W-1:0] color;
  console_view_t     awaited_views [$];
  int                mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void blank_cells(input int unsigned first);
    for (int i = first; i < CELL_COUNT; i++) begin
      screen[ADDR_W'(i)] = {color, CH_SPACE};
    end
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_ROWS) begin
      // scroll: every row moves up one, bottom row gets blanks in the current color
      for (int i = 0; i < SCROLL_BASE; i++) begin
        screen[ADDR_W'(i)] = screen[ADDR_W'(i + SCREEN_COLS)];
      end
      blank_cells(SCROLL_BASE);
      cur_row = SCREEN_ROWS - 1;
    end
  endfunction

  function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
    if (ch == CH_NEWLINE) begin
      advance_line();
    end else if (ch == CH_RETURN) begin
      cur_col = 0;
    end else if (ch == CH_TAB) begin
      cur_col += TAB_STEP;
      if (cur_col >= SCREEN_COLS) advance_line();
    end else begin
      screen[ADDR_W'(cur_row * SCREEN_COLS + cur_col)] = {color, ch};
      cur_col++;
      if (cur_col >= SCREEN_COLS) advance_line();
    end
  endfunction

  function automatic console_view_t step_console(input logic [1:0]        action,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [ROW_W-1:0]  rr,
                                                 input logic [COL_W-1:0]  rc);
    console_view_t view;
    view.entry = '0;
    if (action == ACT_PUT) begin
      put_glyph(ch);
    end else if (action == ACT_CLEAR) begin
      blank_cells(0);
      cur_row = 0;
      cur_col = 0;
    end else if (action == ACT_READ) begin
      // cells off the screen read as zero
      if (rr < SCREEN_ROWS && rc < SCREEN_COLS) begin
        view.entry = screen[ADDR_W'(32'(rr) * SCREEN_COLS + 32'(rc))];
      end
    end
    view.row = ROW_W'(cur_row);
    view.col = COL_W'(cur_col);
    return view;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    console_view_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        screen[ADDR_W'(i)] = BLANK_RESET;
      end
      cur_row = 0;
      cur_col = 0;
      color = COLOR_RESET;
      awaited_views.delete();
      mismatches = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) color = cfg_mon.text_color;
      if (in_mon.valid && in_mon.ready) begin
        awaited_views.push_back(step_console(in_mon.action, in_mon.char_code,
                                             in_mon.read_row, in_mon.read_col));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_views.size() == 0) begin
          report_mismatch("result with no item pending", out_mon.cell_entry, 0);
        end else begin
          want = awaited_views.pop_front();
          if (out_mon.cell_entry !== want.entry) begin
            report_mismatch("cell_entry", out_mon.cell_entry, want.entry);
          end
          if (out_mon.cursor_row !== want.row) begin
            report_mismatch("cursor_row", out_mon.cursor_row, want.row);
          end
          if (out_mon.cursor_col !== want.col) begin
            report_mismatch("cursor_col", out_mon.cursor_col, want.col);
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    awaited_count_o <= awaited_views.size();
  end

endmodule

### test/text_console_writer_test.sv
// Top of the console test: clock, reset, item and color stimulus, final verdict
module text_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 450;

  typedef struct packed {
    logic [1:0]        action;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } console_item_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int          mismatch_count;
  int          awaited_count;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();
  tcw_cfg_if cfg_ch ();

  text_console_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  text_console_mirror mirror (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_mon          (cfg_ch),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // worst case: every item a full-screen sweep, several times over
  initial begin
    #150ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input console_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= it.action;
    in_ch.char_code <= it.char_code;
    in_ch.read_row  <= it.read_row;
    in_ch.read_col  <= it.read_col;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_fields(input logic [1:0] action, input int unsigned ch,
                             input int unsigned rr, input int unsigned rc);
    send_item('{action, CHAR_W'(ch), ROW_W'(rr), COL_W'(rc)});
  endtask

  task automatic write_color(input logic [CHAR_W-1:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.text_color <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0);
  endtask

  // mostly text with line breaks; reads, clears and the unused code now and then
  function automatic console_item_t random_item();
    console_item_t it;
    int unsigned   pick;
    pick = $urandom_range(999);
    it.char_code = CHAR_W'($urandom_range(255));
    it.read_row  = ROW_W'($urandom_range(31));
    it.read_col  = COL_W'($urandom_range(127));
    if (pick < 4) begin
      it.action = ACT_CLEAR;
    end else if (pick < 24) begin
      it.action = ACT_UNUSED;
    end else if (pick < 154) begin
      it.action = ACT_READ;
      if ($urandom_range(9) < 8) begin
        it.read_row = ROW_W'($urandom_range(SCREEN_ROWS - 1));
        it.read_col = COL_W'($urandom_range(SCREEN_COLS - 1));
      end
    end else begin
      it.action = ACT_PUT;
      pick = $urandom_range(99);
      if (pick < 9) it.char_code = CH_NEWLINE;
      else if (pick < 12) it.char_code = CH_RETURN;
      else if (pick < 16) it.char_code = CH_TAB;
    end
    return it;
  endfunction

  initial begin : stimulus
    int unsigned       phase_idle [4];
    int unsigned       phase_stall [4];
    logic [CHAR_W-1:0] phase_color [4];
    phase_idle  = '{0, 82, 0, 15};
    phase_stall = '{0, 0, 82, 15};
    phase_color = '{8'hFF, 8'h00, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255))};
    idle_pct  = 0;
    stall_pct = 0;
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_PUT;
    in_ch.char_code   <= '0;
    in_ch.read_row    <= '0;
    in_ch.read_col    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.text_color <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = phase_idle[phase];
      stall_pct = phase_stall[phase];
      write_color(phase_color[phase]);
      if (phase == 0) begin
        send_fields(ACT_PUT, 8'h41, 0, 0);
        send_fields(ACT_PUT, 8'h00, 0, 0);
        send_fields(ACT_PUT, 8'hFF, 0, 0);
        send_fields(ACT_READ, 0, 0, 0);
        send_fields(ACT_READ, 0, 0, 2);
        send_fields(ACT_PUT, CH_TAB, 0, 0);
        send_fields(ACT_PUT, CH_RETURN, 0, 0);
        send_fields(ACT_PUT, 8'h7A, 0, 0);
        send_fields(ACT_PUT, CH_NEWLINE, 0, 0);
        send_fields(ACT_READ, 0, SCREEN_ROWS - 1, SCREEN_COLS - 1);
        send_fields(ACT_READ, 0, 31, 127);
        send_fields(ACT_READ, 0, SCREEN_ROWS, 0);
        send_fields(ACT_READ, 0, 0, SCREEN_COLS);
        send_fields(ACT_UNUSED, 8'hFF, 31, 127);
        send_fields(ACT_CLEAR, 0, 0, 0);
        send_fields(ACT_READ, 0, 0, 0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item());
      end
      wait_drained();
    end

    repeat (CELL_COUNT + 8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_in_if.sv
rtl/core/tcw_out_if.sv
rtl/core/tcw_cfg_if.sv
rtl/core/tcw_screen_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_checker.sv
test/text_console_mirror.sv
test/text_console_writer_test.sv
